FILE: sv/smrq_pkg.sv
`timescale 1ns / 1ps

package smrq_pkg;

    localparam int ACT_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 6;
    localparam int STAT_W  = 3;
    localparam int OCC_W   = 5;
    localparam int SLOTS_W = 5;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Actions of an input word
    localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_COMMIT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_POP    = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_COMMIT_OK  = 3'd0;
    localparam logic [STAT_W-1:0] ST_COMMIT_REJ = 3'd1;
    localparam logic [STAT_W-1:0] ST_POP_DATA   = 3'd2;
    localparam logic [STAT_W-1:0] ST_POP_EMPTY  = 3'd3;
    localparam logic [STAT_W-1:0] ST_POP_BIG    = 3'd4;

    // Register index, taken from paddr[2]
    localparam logic CFG_IDX_SLOTS = 1'b0;
    localparam logic CFG_IDX_PLIM  = 1'b1;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  reader_capacity;
    } t_in_word;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              last;
        logic [OCC_W-1:0]  occupancy;
    } t_out_word;

    typedef struct packed {
        logic              push;
        logic              commit;
        logic              pop_start;
        logic              pop_check;
        logic              copy_step;
        logic              rd_step;
        logic              load_res;
        logic              load_byte;
        logic [STAT_W-1:0] res_status;
    } t_cmd;

    typedef struct packed {
        logic commit_ok;
        logic copy_needed;
        logic copy_last;
        logic q_empty;
        logic pop_big;
        logic pop_zero;
        logic rd_left;
        logic rdv;
        logic rd_last;
        logic out_free;
    } t_sts;

endpackage

FILE: sv/slotted_message_ring_queue.sv
`timescale 1ns / 1ps

// Slotted message ring queue. A writer sends push words (one message byte
// each) and then a commit word; the commit copies the staged bytes into the
// slot at the tail and answers with one word, status commit ok or commit
// rejected (ring full, or the message grew past the slot payload limit).
// A pop word answers with the oldest message as a run of data words, one
// byte each, last marked; an empty ring or a message longer than the reader
// capacity answers with a single status word and leaves the ring untouched.
// Push and unused actions cause no result. A commit that is rejected or
// carries no bytes goes from acceptance to the emit state, which loads its
// result word; otherwise the copy state first moves the staged bytes from
// the single-port staging buffer into the slot memory one a cycle. A pop
// of an empty ring goes straight to the emit state; a too-large pop or a pop
// of an empty message passes the length check state before the emit state;
// a data pop passes the length check and then the registered payload-memory
// read before its first byte loads, and the rest load one per cycle while
// the output is free. Output stall holds any of these loads. The input
// stalls from the acceptance of a commit or pop until its last result word
// is loaded, and takes the next word in the cycle after that. Slot memories
// start undefined and need no clearing pass: a slot is only used after a
// commit wrote it.
// Registers: 0x0 holds slots_in_use (5 bits, reset 16), 0x4 holds
// slot_payload_bytes (6 bits, reset 56); write them only while the queue
// is idle.
module slotted_message_ring_queue
    import smrq_pkg::*;
#(
    parameter int MAX_SLOTS   = 16,
    parameter int MAX_PAYLOAD = 56
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_word,

    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [SLOTS_W-1:0] r_cfg_slots;
    logic [LEN_W-1:0]   r_cfg_plim;
    t_cmd               cmd;
    t_sts               sts;

    // Config registers: decode on paddr[2], one word per register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_slots <= 5'd16;
            r_cfg_plim  <= 6'd56;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                CFG_IDX_SLOTS: r_cfg_slots <= pwdata[SLOTS_W-1:0];
                CFG_IDX_PLIM:  r_cfg_plim  <= pwdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            CFG_IDX_SLOTS: prdata = {{(APB_DW-SLOTS_W){1'b0}}, r_cfg_slots};
            CFG_IDX_PLIM:  prdata = {{(APB_DW-LEN_W){1'b0}}, r_cfg_plim};
            default:       prdata = '0;
        endcase
    end

    // Sequence commits and pops
    smrq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_word.action),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold the ring, the staging buffer and the output register
    smrq_dp #(
        .MAX_SLOTS   (MAX_SLOTS),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_slots (r_cfg_slots),
        .i_cfg_plim  (r_cfg_plim),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

FILE: sv/smrq_ctrl.sv
`timescale 1ns / 1ps

module smrq_ctrl
    import smrq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [ACT_W-1:0] i_action,
    output logic             o_in_stall,
    input  t_sts             i_sts,
    output t_cmd             o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_COPY   = 3'd1;
    localparam logic [2:0] S_EMIT   = 3'd2;
    localparam logic [2:0] S_CHK    = 3'd3;
    localparam logic [2:0] S_STREAM = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [STAT_W-1:0] r_kind, n_kind;
    logic              accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.res_status = r_kind;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_action)
                        ACT_PUSH: begin
                            o_cmd.push = 1'b1;
                        end
                        ACT_COMMIT: begin
                            o_cmd.commit = 1'b1;
                            n_kind  = i_sts.commit_ok ? ST_COMMIT_OK : ST_COMMIT_REJ;
                            n_state = i_sts.copy_needed ? S_COPY : S_EMIT;
                        end
                        ACT_POP: begin
                            if (i_sts.q_empty) begin
                                n_kind  = ST_POP_EMPTY;
                                n_state = S_EMIT;
                            end else begin
                                o_cmd.pop_start = 1'b1;
                                n_state = S_CHK;
                            end
                        end
                        default: begin
                            // unused action: drop the word
                        end
                    endcase
                end
            end
            S_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_sts.copy_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_res = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CHK: begin
                if (i_sts.pop_big) begin
                    n_kind  = ST_POP_BIG;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.pop_check = 1'b1;
                    n_kind  = ST_POP_DATA;
                    n_state = i_sts.pop_zero ? S_EMIT : S_STREAM;
                end
            end
            S_STREAM: begin
                o_cmd.rd_step   = i_sts.rd_left && (!i_sts.rdv || i_sts.out_free);
                o_cmd.load_byte = i_sts.rdv && i_sts.out_free;
                if (o_cmd.load_byte && i_sts.rd_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= ST_COMMIT_OK;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

FILE: sv/smrq_dp.sv
`timescale 1ns / 1ps

module smrq_dp
    import smrq_pkg::*;
#(
    parameter int MAX_SLOTS   = 16,
    parameter int MAX_PAYLOAD = 56
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_in_word           i_in_word,
    input  logic [SLOTS_W-1:0] i_cfg_slots,
    input  logic [LEN_W-1:0]   i_cfg_plim,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output t_out_word          o_out_word
);

    localparam int IW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SW     = $clog2(MAX_SLOTS + 1);
    localparam int PW     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int PDEPTH = MAX_SLOTS * (2 ** PW);

    // Storage
    logic [BYTE_W-1:0] staging   [0:(2**PW)-1];
    logic [LEN_W-1:0]  len_store [0:MAX_SLOTS-1];
    logic [BYTE_W-1:0] pay_store [0:PDEPTH-1];

    // Control registers
    logic [IW-1:0]    r_head, r_tail;
    logic [SW-1:0]    r_count;
    logic [LEN_W-1:0] r_pend;
    logic             r_ovf;
    logic             r_cwv;
    logic             r_rdv;
    logic             r_out_valid;

    // Payload registers
    logic [IW-1:0]     r_cslot, r_pslot;
    logic [LEN_W-1:0]  r_clen, r_cidx, r_plen, r_pidx, r_cap, r_len_rd;
    logic [PW-1:0]     r_cwidx;
    logic [BYTE_W-1:0] r_stg_rd, r_rd;
    logic              r_rd_last;
    t_out_word         r_out;

    logic [SW-1:0]    eff_slots;
    logic [LEN_W-1:0] eff_plim, len_sat, cap_sat;
    logic             commit_ok, push_fits, out_free;

    function automatic logic [IW-1:0] adv(input logic [IW-1:0] idx,
                                          input logic [SW-1:0] lim);
        logic [IW:0] n;
        n = {1'b0, idx} + 1'b1;
        return (n >= (IW+1)'(lim)) ? '0 : n[IW-1:0];
    endfunction

    always_comb begin
        if (i_cfg_slots == '0) begin
            eff_slots = SW'(1);
        end else if ({27'd0, i_cfg_slots} > 32'(MAX_SLOTS)) begin
            eff_slots = SW'(MAX_SLOTS);
        end else begin
            eff_slots = SW'(i_cfg_slots);
        end
    end

    assign eff_plim  = (i_cfg_plim > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : i_cfg_plim;
    assign cap_sat   = (i_in_word.reader_capacity > LEN_W'(MAX_PAYLOAD)) ?
                       LEN_W'(MAX_PAYLOAD) : i_in_word.reader_capacity;
    assign len_sat   = (r_len_rd > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : r_len_rd;
    assign push_fits = (r_pend < eff_plim);
    assign commit_ok = !r_ovf && (r_pend <= eff_plim) && (r_count < eff_slots);
    assign out_free  = !r_out_valid || !i_out_stall;

    assign o_sts.commit_ok   = commit_ok;
    assign o_sts.copy_needed = commit_ok && (r_pend != '0);
    assign o_sts.copy_last   = ((r_cidx + 1'b1) == r_clen);
    assign o_sts.q_empty     = (r_count == '0);
    assign o_sts.pop_big     = (len_sat > r_cap);
    assign o_sts.pop_zero    = (len_sat == '0);
    assign o_sts.rd_left     = (r_pidx < r_plen);
    assign o_sts.rdv         = r_rdv;
    assign o_sts.rd_last     = r_rd_last;
    assign o_sts.out_free    = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Ring pointers, pending message and handshake state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_pend      <= '0;
            r_ovf       <= 1'b0;
            r_cwv       <= 1'b0;
            r_rdv       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                if (push_fits) begin
                    r_pend <= r_pend + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_pend <= '0;
                r_ovf  <= 1'b0;
                if (commit_ok) begin
                    r_tail  <= adv(r_tail, eff_slots);
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.pop_check && !o_sts.pop_big) begin
                r_head  <= adv(r_head, eff_slots);
                r_count <= r_count - 1'b1;
            end
            r_cwv <= i_cmd.copy_step;
            if (i_cmd.rd_step) begin
                r_rdv <= 1'b1;
            end else if (i_cmd.load_byte) begin
                r_rdv <= 1'b0;
            end
            if (i_cmd.load_res || i_cmd.load_byte) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Staging buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && push_fits) begin
            staging[r_pend[PW-1:0]] <= i_in_word.data_byte;
        end
        if (i_cmd.copy_step) begin
            r_stg_rd <= staging[r_cidx[PW-1:0]];
        end
    end

    // Length store, read continuously at the head slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && commit_ok) begin
            len_store[r_tail] <= r_pend;
        end
        r_len_rd <= len_store[r_head];
    end

    // Payload store
    always_ff @(posedge i_clk) begin
        if (r_cwv) begin
            pay_store[{r_cslot, r_cwidx}] <= r_stg_rd;
        end
        if (i_cmd.rd_step) begin
            r_rd <= pay_store[{r_pslot, r_pidx[PW-1:0]}];
        end
    end

    // Copy, pop and output payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_cslot <= r_tail;
            r_clen  <= r_pend;
            r_cidx  <= '0;
        end
        if (i_cmd.copy_step) begin
            r_cwidx <= r_cidx[PW-1:0];
            r_cidx  <= r_cidx + 1'b1;
        end
        if (i_cmd.pop_start) begin
            r_cap <= cap_sat;
        end
        if (i_cmd.pop_check) begin
            r_pslot <= r_head;
            r_plen  <= len_sat;
            r_pidx  <= '0;
        end
        if (i_cmd.rd_step) begin
            r_rd_last <= ((r_pidx + 1'b1) == r_plen);
            r_pidx    <= r_pidx + 1'b1;
        end
        if (i_cmd.load_res) begin
            r_out.status     <= i_cmd.res_status;
            r_out.out_byte   <= '0;
            r_out.byte_valid <= 1'b0;
            r_out.last       <= 1'b1;
            r_out.occupancy  <= OCC_W'(r_count);
        end else if (i_cmd.load_byte) begin
            r_out.status     <= ST_POP_DATA;
            r_out.out_byte   <= r_rd;
            r_out.byte_valid <= 1'b1;
            r_out.last       <= r_rd_last;
            r_out.occupancy  <= OCC_W'(r_count);
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_SLOTS)
        else $error("queued count beyond slot count");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pend) <= MAX_PAYLOAD)
        else $error("pending length beyond payload size");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_res || i_cmd.load_byte) |-> out_free)
        else $error("output register overwritten while stalled");

    a_rdv_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rdv) |-> $past(i_cmd.rd_step))
        else $error("read data marked valid without a read");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import smrq_pkg::*;

    localparam int RING_SLOTS   = 16;
    localparam int RING_PAYLOAD = 56;
    localparam int SETTLE_CYCLES = 80;      // longest commit plus output slack
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_WORDS   = 6;

    // Action code that the block must ignore
    localparam logic [ACT_W-1:0] ACT_IDLE = 2'd3;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    slotted_message_ring_queue #(
        .MAX_SLOTS   (RING_SLOTS),
        .MAX_PAYLOAD (RING_PAYLOAD)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the ring: registers, slots, indices, staging buffer
    // ------------------------------------------------------------------
    logic [SLOTS_W-1:0] cfg_slots = 5'd16;
    logic [LEN_W-1:0]   cfg_plim  = 6'd56;

    logic [BYTE_W-1:0] slot_bytes [RING_SLOTS][RING_PAYLOAD];
    int                slot_len   [RING_SLOTS];
    logic [BYTE_W-1:0] staged     [RING_PAYLOAD];
    int  ring_head  = 0;
    int  ring_tail  = 0;
    int  ring_count = 0;
    int  staged_len = 0;
    bit  staged_ovf = 1'b0;

    // Result words still owed by the block, oldest first
    t_out_word awaited_replies[$];

    // A directed row may carry its reply typed in by hand; it then stands
    // in for the predicted word of that one item.
    bit        typed_pending = 1'b0;
    t_out_word typed_reply;

    int  mismatches    = 0;
    int  words_sent    = 0;
    int  replies_seen  = 0;
    int  settings_run  = 1;
    int  cycle_count   = 0;
    bit  calm          = 1'b0;      // no idling on either side

    function automatic int live_slots();
        if (cfg_slots == 0) return 1;
        if (cfg_slots > RING_SLOTS) return RING_SLOTS;
        return int'(cfg_slots);
    endfunction

    function automatic int live_plim();
        return (cfg_plim > RING_PAYLOAD) ? RING_PAYLOAD : int'(cfg_plim);
    endfunction

    function automatic int next_index(input int idx);
        return (idx + 1 >= live_slots()) ? 0 : idx + 1;
    endfunction

    function automatic t_in_word make_word(input logic [ACT_W-1:0] act,
                                           input logic [BYTE_W-1:0] data,
                                           input logic [LEN_W-1:0] cap);
        t_in_word w;
        w.action          = act;
        w.data_byte       = data;
        w.reader_capacity = cap;
        return w;
    endfunction

    function automatic t_out_word closing_word(input logic [STAT_W-1:0] st,
                                               input int occ);
        return '{status: st, out_byte: 8'h00, byte_valid: 1'b0, last: 1'b1,
                 occupancy: OCC_W'(occ)};
    endfunction

    // Queue one owed reply; occupancy is the count after the operation
    function automatic void owe_reply(input logic [STAT_W-1:0] st,
                                      input logic [BYTE_W-1:0] data,
                                      input logic valid, input logic fin);
        t_out_word r;
        r = '{status: st, out_byte: data, byte_valid: valid, last: fin,
              occupancy: OCC_W'(ring_count)};
        if (typed_pending) begin
            r = typed_reply;
            typed_pending = 1'b0;
        end
        awaited_replies.push_back(r);
    endfunction

    // Advance the shadow ring by one accepted input word
    function automatic void apply_queue_op(input t_in_word w);
        int  cap;
        int  len;
        int  slot;
        bit  ok;
        case (w.action)
            ACT_PUSH: begin
                if (staged_len < live_plim()) begin
                    staged[staged_len] = w.data_byte;
                    staged_len++;
                end else begin
                    staged_ovf = 1'b1;
                end
            end
            ACT_COMMIT: begin
                ok = !staged_ovf && staged_len <= live_plim()
                     && ring_count < live_slots();
                if (ok) begin
                    slot = ring_tail % RING_SLOTS;
                    for (int i = 0; i < staged_len; i++)
                        slot_bytes[slot][i] = staged[i];
                    slot_len[slot] = staged_len;
                    ring_tail = next_index(ring_tail);
                    ring_count++;
                end
                staged_len = 0;
                staged_ovf = 1'b0;
                owe_reply(ok ? ST_COMMIT_OK : ST_COMMIT_REJ, 8'h00, 1'b0, 1'b1);
            end
            ACT_POP: begin
                if (ring_count == 0) begin
                    owe_reply(ST_POP_EMPTY, 8'h00, 1'b0, 1'b1);
                end else begin
                    cap  = (w.reader_capacity > RING_PAYLOAD) ? RING_PAYLOAD
                                                              : int'(w.reader_capacity);
                    slot = ring_head % RING_SLOTS;
                    len  = slot_len[slot];
                    if (len > cap) begin
                        owe_reply(ST_POP_BIG, 8'h00, 1'b0, 1'b1);
                    end else begin
                        ring_head = next_index(ring_head);
                        ring_count--;
                        if (len == 0)
                            owe_reply(ST_POP_DATA, 8'h00, 1'b0, 1'b1);
                        for (int i = 0; i < len; i++)
                            owe_reply(ST_POP_DATA, slot_bytes[slot][i], 1'b1,
                                      (i + 1 == len));
                    end
                end
            end
            default: ;  // unused action: no effect, no reply
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side: hold the word until accepted, then update the shadow
    // ------------------------------------------------------------------
    task automatic send_word(input t_in_word w);
        int gap;
        // Insert an idle burst before the word now and then
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        apply_queue_op(w);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_word(make_word(ACT_PUSH, 8'($urandom), 6'($urandom)));
        send_word(make_word(ACT_COMMIT, 8'($urandom), 6'($urandom)));
    endtask

    // Drop valid, wait out every owed reply, then let the block go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where pready is seen with penable high.
    task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_IDX_SLOTS) cfg_slots = value[SLOTS_W-1:0];
        else                      cfg_plim  = value[LEN_W-1:0];
    endtask

    // Mostly whole messages with random bytes, some pops, a little noise;
    // drain the ring at the end so the slot count may change safely.
    task automatic random_phase(input int budget);
        int       start;
        int       pick;
        int       len;
        int       lim;
        t_in_word w;
        start = words_sent;
        while (words_sent - start < budget) begin
            pick = $urandom_range(0, 9);
            lim  = live_plim();
            if (pick < 5) begin
                // Try the limit edge only where the messages stay short
                if (lim < 16 && $urandom_range(0, 5) == 0)
                    len = lim + 1 - $urandom_range(0, (lim == 0) ? 1 : 2);
                else
                    len = $urandom_range(0, (lim + 1 < 6) ? lim + 1 : 6);
                send_message(len);
            end else if (pick < 9) begin
                send_word(make_word(ACT_POP, 8'($urandom),
                                    6'($urandom_range(0, 63))));
            end else begin
                w = t_in_word'($urandom);
                if (w.action == ACT_PUSH) w.action = ACT_IDLE;
                send_word(w);
            end
        end
        while (ring_count != 0)
            send_word(make_word(ACT_POP, 8'($urandom), 6'd63));
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall bursts, free stretches in between
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 13);
        end else begin
            i_out_stall <= 1'b0;
            stall_left  <= $urandom_range(0, 20);
        end
    end

    // Compare each accepted result word with the oldest owed reply
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            replies_seen++;
            if (awaited_replies.size() == 0) begin
                $error("result word with no reply owed: %h", o_out_word);
                mismatches++;
            end else begin
                want = awaited_replies.pop_front();
                if (o_out_word.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status,
                           o_out_word.status);
                    mismatches++;
                end
                if (o_out_word.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte,
                           o_out_word.out_byte);
                    mismatches++;
                end
                if (o_out_word.byte_valid !== want.byte_valid) begin
                    $error("byte_valid: expected %0d, got %0d", want.byte_valid,
                           o_out_word.byte_valid);
                    mismatches++;
                end
                if (o_out_word.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last,
                           o_out_word.last);
                    mismatches++;
                end
                if (o_out_word.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy,
                           o_out_word.occupancy);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("slotted_message_ring_queue regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed plan, walked at the reset settings
    // ------------------------------------------------------------------
    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word reply;
    } t_plan_row;

    t_plan_row plan[$];

    function automatic void add_row(input t_in_word w, input bit typed = 1'b0,
                                    input t_out_word reply = '0);
        plan.push_back('{w: w, typed: typed, reply: reply});
    endfunction

    initial begin
        int slots_plan [6] = '{1, 3, 0, 31, 16, 7};
        int plim_plan  [6] = '{0, 5, 63, 12, 56, 8};

        // Empty ring, then an empty message committed and popped
        add_row(make_word(ACT_POP,    8'h00, 6'd0),  1, closing_word(ST_POP_EMPTY, 0));
        add_row(make_word(ACT_COMMIT, 8'h00, 6'd0),  1, closing_word(ST_COMMIT_OK, 1));
        add_row(make_word(ACT_POP,    8'h00, 6'd0),  1, closing_word(ST_POP_DATA, 0));
        // Three bytes, two at the byte extremes; too-small reader first
        add_row(make_word(ACT_PUSH,   8'h00, 6'd0));
        add_row(make_word(ACT_PUSH,   8'hFF, 6'd63));
        add_row(make_word(ACT_PUSH,   8'hA5, 6'd0));
        add_row(make_word(ACT_COMMIT, 8'h00, 6'd0),  1, closing_word(ST_COMMIT_OK, 1));
        add_row(make_word(ACT_POP,    8'h00, 6'd2),  1, closing_word(ST_POP_BIG, 1));
        add_row(make_word(ACT_POP,    8'h00, 6'd63));
        // Unused action with every bit set: ignored
        add_row(make_word(ACT_IDLE,   8'hFF, 6'd63));
        add_row(make_word(ACT_COMMIT, 8'hFF, 6'd63), 1, closing_word(ST_COMMIT_OK, 1));
        add_row(make_word(ACT_PUSH,   8'h5A, 6'd63));
        add_row(make_word(ACT_COMMIT, 8'h00, 6'd0),  1, closing_word(ST_COMMIT_OK, 2));
        add_row(make_word(ACT_POP,    8'h00, 6'd0));
        add_row(make_word(ACT_POP,    8'h00, 6'd0),  1, closing_word(ST_POP_BIG, 1));
        add_row(make_word(ACT_POP,    8'h00, 6'd1));
        add_row(make_word(ACT_POP,    8'h00, 6'd56), 1, closing_word(ST_POP_EMPTY, 0));

        // Hold reset, then release for good
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            typed_pending = plan[i].typed;
            typed_reply   = plan[i].reply;
            send_word(plan[i].w);
        end

        // Full-length message to an exact-size reader
        send_message(RING_PAYLOAD);
        send_word(make_word(ACT_POP, 8'h00, 6'(RING_PAYLOAD)));

        random_phase(PHASE_WORDS);

        // Walk the register settings, extremes and out-of-range values too
        foreach (slots_plan[p]) begin
            settle();
            write_reg(CFG_IDX_SLOTS, APB_DW'(slots_plan[p]));
            write_reg(CFG_IDX_PLIM,  APB_DW'(plim_plan[p]));
            settings_run++;
            if (p == 5) calm = 1'b1;
            random_phase(PHASE_WORDS);
        end

        settle();

        $display("sent %0d input words over %0d register settings", words_sent,
                 settings_run);
        $display("checked %0d result words, %0d mismatches", replies_seen, mismatches);
        if (mismatches == 0 && awaited_replies.size() == 0) begin
            $display("slotted_message_ring_queue regression: pass");
        end else begin
            $display("slotted_message_ring_queue regression: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/smrq_pkg.sv
sv/smrq_ctrl.sv
sv/smrq_dp.sv
sv/slotted_message_ring_queue.sv
tb/sv/testbench.sv
